// ===== hdl/pcx_pkg.sv =====
`default_nettype none

package pcx_pkg;

    localparam int GENE_W        = 6;
    localparam int LEN_W         = 7;
    localparam int GENE_SPAN     = 64;
    localparam int MAX_GENES_DEF = 64;
    localparam int MIN_LEN       = 2;

    localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // one gene pair write into the parent stores
    typedef struct packed {
        logic              en;
        logic [GENE_W-1:0] position;
        logic [GENE_W-1:0] gene_a;
        logic [GENE_W-1:0] gene_b;
    } store_wr_t;

endpackage

`default_nettype wire

// ===== hdl/pcx_if.sv =====
`default_nettype none

interface pcx_item_if import pcx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [GENE_W-1:0] position;
    logic [GENE_W-1:0] gene_a;
    logic [GENE_W-1:0] gene_b;

    modport source (output valid, command, position, gene_a, gene_b, input ready);
    modport sink   (input valid, command, position, gene_a, gene_b, output ready);
endinterface

interface pcx_result_if import pcx_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [GENE_W-1:0] index;
    logic [GENE_W-1:0] child_a;
    logic [GENE_W-1:0] child_b;
    logic              last_gene;

    modport source (output valid, index, child_a, child_b, last_gene, input ready);
    modport sink   (input valid, index, child_a, child_b, last_gene, output ready);
endinterface

`default_nettype wire

// ===== hdl/pcx_gene_store.sv =====
`default_nettype none

module pcx_gene_store import pcx_pkg::*; #(
    parameter int MAX_GENES = MAX_GENES_DEF
) (
    input  wire logic                           clk,
    input  wire store_wr_t                      wr,
    input  wire logic [$clog2(MAX_GENES)-1:0]   pa_addr,
    input  wire logic [$clog2(MAX_GENES)-1:0]   pb_addr,
    input  wire logic [GENE_W-1:0]              wa_addr,
    output logic      [GENE_W-1:0]              pa_data,
    output logic      [GENE_W-1:0]              pb_data,
    output logic      [$clog2(MAX_GENES)-1:0]   wa_data
);

    localparam int AW    = $clog2(MAX_GENES);
    localparam int DEPTH = 1 << AW;

    logic [GENE_W-1:0] pa_mem [DEPTH];
    logic [GENE_W-1:0] pb_mem [DEPTH];
    logic [AW-1:0]     wa_mem [GENE_SPAN];

    // parent A, parent B, and the inverse map of parent A
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            pa_mem[wr.position[AW-1:0]] <= wr.gene_a;
            pb_mem[wr.position[AW-1:0]] <= wr.gene_b;
            wa_mem[wr.gene_a]           <= wr.position[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        pa_data <= pa_mem[pa_addr];
        pb_data <= pb_mem[pb_addr];
        wa_data <= wa_mem[wa_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/permutation_cycle_crossover_top.sv =====
// Load command or ignored start: taken in S_IDLE; loads stream at one transfer per cycle while
// idle. Start: taken in S_IDLE, then per position on the cycle a walk step S_WB, S_WW, S_WA,
// S_CHK (a chain of three registered reads: parent B, inverse map of A, parent A; then the
// check). Emission, when the marked count reaches length/3: length results, each read in S_ERD,
// held in S_EOUT until taken. Reset: marks and count cleared, length 64; gene stores undefined.
`default_nettype none

module permutation_cycle_crossover_top import pcx_pkg::*; #(
    parameter int MAX_GENES = MAX_GENES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire logic [LEN_W-1:0] cfg_wdata,
    pcx_item_if.sink              item,
    pcx_result_if.source          result
);

    localparam int AW    = $clog2(MAX_GENES);
    localparam int DEPTH = 1 << AW;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0; // take loads and starts
    localparam logic [2:0] S_WB   = 3'd1; // read parent B at current position
    localparam logic [2:0] S_WW   = 3'd2; // look up that gene in parent A's inverse map
    localparam logic [2:0] S_WA   = 3'd3; // read parent A at the candidate
    localparam logic [2:0] S_CHK  = 3'd4; // accept step or end the walk
    localparam logic [2:0] S_ERD  = 3'd5; // read genes for the next result
    localparam logic [2:0] S_EOUT = 3'd6; // result on the port, wait for transfer

    logic [2:0]        state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [DEPTH-1:0]  marks_reg, marks_next;
    logic [AW-1:0]     x_reg, x_next;
    logic [AW-1:0]     nxt_reg, nxt_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [GENE_W-1:0] want_reg, want_next;

    logic [LEN_W-1:0]  len_eff;
    logic [AW-1:0]     pos_a;
    logic              pos_ok;
    logic              step_ok;
    logic              emit_go;
    logic              last;
    logic              mark_out;
    logic [8:0]        thresh;

    store_wr_t         st_wr;
    logic [AW-1:0]     pa_addr, pb_addr;
    logic [GENE_W-1:0] pa_data, pb_data;
    logic [AW-1:0]     wa_data;

    // effective length: register clamped to [MIN_LEN, MAX_GENES]
    always_comb
    begin
        if (len_reg < LEN_W'(MIN_LEN))
            len_eff = LEN_W'(MIN_LEN);
        else if (len_reg > LEN_W'(MAX_GENES))
            len_eff = LEN_W'(MAX_GENES);
        else
            len_eff = len_reg;
    end

    assign pos_a  = item.position[AW-1:0];
    assign pos_ok = LEN_W'(item.position) < len_eff;

    // walk step passes when the candidate is in range, A really holds the gene
    // there, and the candidate is not yet on the cycle
    assign step_ok = (LEN_W'(nxt_reg) < len_eff) && (pa_data == want_reg)
                     && !marks_reg[nxt_reg];

    // count < len/3  <=>  3*(count+1) <= len, so emit when 3*(count+1) > len
    assign thresh  = 9'({count_reg, 1'b0}) + 9'(count_reg) + 9'd3;
    assign emit_go = thresh > 9'(len_eff);

    assign last     = LEN_W'(idx_reg) == (len_eff - LEN_W'(1));
    assign mark_out = marks_reg[idx_reg];

    assign item.ready = (state_reg == S_IDLE);

    assign result.valid     = (state_reg == S_EOUT);
    assign result.index     = GENE_W'(idx_reg);
    assign result.child_a   = mark_out ? pa_data : pb_data;
    assign result.child_b   = mark_out ? pb_data : pa_data;
    assign result.last_gene = last;

    // store write on a load transfer within the length
    always_comb
    begin
        st_wr.en       = item.valid && item.ready && (item.command == CMD_LOAD) && pos_ok;
        st_wr.position = item.position;
        st_wr.gene_a   = item.gene_a;
        st_wr.gene_b   = item.gene_b;
    end

    assign pb_addr = (state_reg == S_WB) ? x_reg : idx_reg;
    assign pa_addr = (state_reg == S_WA) ? wa_data : idx_reg;

    pcx_gene_store #(
        .MAX_GENES (MAX_GENES)
    ) u_store (
        .clk     (clk),
        .wr      (st_wr),
        .pa_addr (pa_addr),
        .pb_addr (pb_addr),
        .wa_addr (pb_data),
        .pa_data (pa_data),
        .pb_data (pb_data),
        .wa_data (wa_data)
    );

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        count_next = count_reg;
        marks_next = marks_reg;
        x_next     = x_reg;
        nxt_next   = nxt_reg;
        idx_next   = idx_reg;
        want_next  = want_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid && item.command == CMD_START && pos_ok && !marks_reg[pos_a])
                begin
                    marks_next[pos_a] = 1'b1;
                    count_next        = count_reg + LEN_W'(1);
                    x_next            = pos_a;
                    state_next        = S_WB;
                end
            end
            S_WB:
            begin
                state_next = S_WW;
            end
            S_WW:
            begin
                want_next  = pb_data;
                state_next = S_WA;
            end
            S_WA:
            begin
                nxt_next   = wa_data;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (step_ok)
                begin
                    marks_next[nxt_reg] = 1'b1;
                    count_next          = count_reg + LEN_W'(1);
                    x_next              = nxt_reg;
                    state_next          = S_WB;
                end
                else if (emit_go)
                begin
                    idx_next   = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ERD:
            begin
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                if (result.ready)
                begin
                    if (last)
                    begin
                        marks_next = '0;
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // length write restarts the marking
        if (cfg_write)
        begin
            len_next   = cfg_wdata;
            marks_next = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= LEN_RESET;
            count_reg <= '0;
            marks_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            marks_reg <= marks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        nxt_reg  <= nxt_next;
        idx_reg  <= idx_next;
        want_reg <= want_next;
    end

`ifndef SYNTHESIS
    // each position counts once, so the count never passes the length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= len_eff)
        else $error("marked count above length");

    // the marked count always equals the number of marks
    a_count_marks: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) == $countones(marks_reg))
        else $error("marked count out of step with marks");

    // after the final result of an offspring the marks are gone
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && result.last_gene && !cfg_write)
        |=> (marks_reg == '0) && (count_reg == '0))
        else $error("marks not cleared after last result");

    // no input transfer while a result is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !item.ready)
        else $error("input taken during emission");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
module tb;
    import pcx_pkg::*;

    // Full hold-off after the last expected result: a start that emits nothing may
    // still be walking (S_WB, S_WW, S_WA, S_CHK per step, up to 64 steps).
    localparam int SETTLE_CYCLES = 300;
    // Random part stops after this many items that actually touch the block state.
    localparam int RANDOM_ITEMS  = 220;

    typedef struct packed {
        logic [GENE_W-1:0] index;
        logic [GENE_W-1:0] child_a;
        logic [GENE_W-1:0] child_b;
        logic              last_gene;
    } offspring_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_write;
    logic [LEN_W-1:0] cfg_wdata;

    pcx_item_if   item_bus ();
    pcx_result_if result_bus ();

    permutation_cycle_crossover_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_wdata (cfg_wdata),
        .item      (item_bus),
        .result    (result_bus)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Crossover predictor: private copy of parents, inverse map, marks
    // ------------------------------------------------------------------
    logic [GENE_W-1:0] parent_a   [GENE_SPAN];
    logic [GENE_W-1:0] parent_b   [GENE_SPAN];
    logic [GENE_W-1:0] slot_of_a  [GENE_SPAN];   // position of each gene value in parent A
    bit                on_cycle   [GENE_SPAN];
    int unsigned       marked;
    logic [LEN_W-1:0]  length_reg;

    offspring_t        offspring_q [$];          // expected offspring pairs, oldest first
    int unsigned       emissions;                // number of predicted offspring bursts
    int unsigned       applied_items;            // items that changed the state
    int unsigned       mismatches;

    // Sender / receiver pacing
    int unsigned       burst_left;
    bit                sender_steady;
    bit                sink_steady;

    function automatic int unsigned active_len();
        int unsigned n;
        n = length_reg;
        if (n < MIN_LEN)
            n = MIN_LEN;
        if (n > MAX_GENES_DEF)
            n = MAX_GENES_DEF;
        return n;
    endfunction

    function automatic void clear_cycle();
        foreach (on_cycle[i])
            on_cycle[i] = 1'b0;
        marked = 0;
    endfunction

    // Apply one accepted item; queue the offspring it produces.
    // Returns 1 when the item was not ignored.
    function automatic bit predict_crossover(input logic cmd, input logic [GENE_W-1:0] pos,
                                             input logic [GENE_W-1:0] ga,
                                             input logic [GENE_W-1:0] gb);
        int unsigned n;
        int unsigned x;
        int unsigned nxt;
        logic [GENE_W-1:0] want;
        offspring_t pair;
        n = active_len();
        if (cmd == CMD_LOAD)
        begin
            if (pos >= n)
                return 1'b0;
            parent_a[pos] = ga;
            parent_b[pos] = gb;
            slot_of_a[ga] = pos;
            return 1'b1;
        end
        if (pos >= n || on_cycle[pos])
            return 1'b0;
        x = pos;
        on_cycle[x] = 1'b1;
        marked++;
        // follow B -> A; stop at a stale map entry, out-of-range slot or closed loop
        for (int s = 0; s < n; s++)
        begin
            want = parent_b[x];
            nxt  = slot_of_a[want];
            if (nxt >= n || parent_a[nxt] != want || on_cycle[nxt])
                break;
            on_cycle[nxt] = 1'b1;
            marked++;
            x = nxt;
        end
        if (marked < n / 3)
            return 1'b1;
        for (int i = 0; i < n; i++)
        begin
            pair.index     = GENE_W'(i);
            pair.child_a   = on_cycle[i] ? parent_a[i] : parent_b[i];
            pair.child_b   = on_cycle[i] ? parent_b[i] : parent_a[i];
            pair.last_gene = (i == n - 1);
            offspring_q.insert(offspring_q.size(), pair);
        end
        clear_cycle();
        emissions++;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every transfer on the result channel is matched
    // against the oldest expected pair.
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [GENE_W-1:0] want,
                                        input logic [GENE_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        offspring_t want;
        if (rst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
        begin
            if (offspring_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: expected no result, got index %0d child_a %0d child_b %0d last %0b",
                         $time, result_bus.index, result_bus.child_a, result_bus.child_b,
                         result_bus.last_gene);
            end
            else
            begin
                want = offspring_q.pop_front();
                check_field("index",     want.index,     result_bus.index);
                check_field("child_a",   want.child_a,   result_bus.child_a);
                check_field("child_b",   want.child_b,   result_bus.child_b);
                check_field("last_gene", GENE_W'(want.last_gene), GENE_W'(result_bus.last_gene));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: rotating stall pattern, reloaded when its age counter runs out.
    // Bit 0 forced high so a stall never lasts a full rotation of the pattern.
    // ------------------------------------------------------------------
    logic [15:0] stall_pat = 16'hFFFF;
    int unsigned stall_age = 0;

    always @(negedge clk)
    begin
        if (stall_age == 0)
        begin
            stall_pat = 16'($urandom()) | 16'h0001;
            stall_age = $urandom_range(16, 96);
        end
        else
        begin
            stall_pat = {stall_pat[0], stall_pat[15:1]};
            stall_age--;
        end
        result_bus.ready <= sink_steady || stall_pat[0];
    end

    // ------------------------------------------------------------------
    // Item sender: bursts of random length with random gaps between them, or no gaps when steady.
    // Valid stays high across back-to-back transfers inside a burst.
    // ------------------------------------------------------------------
    task automatic send_item(input logic cmd, input logic [GENE_W-1:0] pos,
                             input logic [GENE_W-1:0] ga, input logic [GENE_W-1:0] gb);
        int unsigned gap;
        if (!sender_steady && burst_left == 0)
        begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            @(negedge clk);
            item_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_bus.valid    <= 1'b1;
        item_bus.command  <= cmd;
        item_bus.position <= pos;
        item_bus.gene_a   <= ga;
        item_bus.gene_b   <= gb;
        do
            @(posedge clk);
        while (item_bus.ready !== 1'b1);
        if (burst_left != 0)
            burst_left--;
        if (predict_crossover(cmd, pos, ga, gb))
            applied_items++;
    endtask

    task automatic load_gene(input int unsigned pos, input int unsigned ga, input int unsigned gb);
        send_item(CMD_LOAD, GENE_W'(pos), GENE_W'(ga), GENE_W'(gb));
    endtask

    // Start commands carry random don't-care gene fields.
    task automatic start_cycle(input int unsigned pos);
        send_item(CMD_START, GENE_W'(pos), GENE_W'($urandom()), GENE_W'($urandom()));
    endtask

    // Drop valid, wait for every expected pair, then let a pending walk finish.
    task automatic settle();
        @(negedge clk);
        item_bus.valid <= 1'b0;
        burst_left = 0;
        while (offspring_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Only called while idle; a length write also wipes the marks.
    task automatic set_length(input logic [LEN_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        length_reg = value;
        clear_cycle();
    endtask

    // Load a random pair of parents over positions 0..n-1: A holds n distinct
    // values out of 0..63, B is a shuffle of A. Positions go in random order.
    task automatic load_parents(input int unsigned n);
        logic [GENE_W-1:0] pool   [GENE_SPAN];
        logic [GENE_W-1:0] shuf_b [GENE_SPAN];
        int unsigned       order  [GENE_SPAN];
        int unsigned       j;
        logic [GENE_W-1:0] t;
        int unsigned       u;
        for (int i = 0; i < GENE_SPAN; i++)
        begin
            pool[i]  = GENE_W'(i);
            order[i] = i;
        end
        for (int i = GENE_SPAN - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = pool[i]; pool[i] = pool[j]; pool[j] = t;
        end
        for (int i = 0; i < n; i++)
            shuf_b[i] = pool[i];
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = shuf_b[i]; shuf_b[i] = shuf_b[j]; shuf_b[j] = t;
            u = order[i]; order[i] = order[j]; order[j] = u;
        end
        for (int k = 0; k < n; k++)
            load_gene(order[k], pool[order[k]], shuf_b[order[k]]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Full-length fill right after reset: every parent slot and every inverse
    // map entry gets written, so no later walk can read an unwritten entry.
    task automatic test_full_fill();
        int unsigned e0;
        e0 = emissions;
        load_parents(GENE_SPAN);
        while (emissions == e0)
            start_cycle($urandom_range(0, GENE_SPAN - 1));
        settle();
    endtask

    task automatic test_directed();
        // Length 2: length/3 is zero, so the first accepted start emits.
        set_length(LEN_W'(2));
        load_gene(0, 63, 0);
        load_gene(1, 0, 63);
        load_gene(63, 21, 42);      // out of range, dropped
        start_cycle(63);            // out of range, dropped
        start_cycle(1);             // walks the permutation cycle {1,0}
        load_gene(0, 5, 5);
        start_cycle(0);             // fixed point counted once
        settle();

        // Length 6: two marks needed before emission.
        set_length(LEN_W'(6));
        load_gene(0, 8, 8);
        load_gene(1, 9, 10);
        load_gene(2, 10, 9);
        load_gene(3, 11, 11);
        load_gene(4, 12, 60);
        load_gene(5, 13, 13);
        start_cycle(0);             // one mark, no emission
        start_cycle(0);             // already marked, dropped
        start_cycle(1);             // cycle {1,2} pushes the count over
        start_cycle(3);             // one mark left pending
        settle();

        // Rewriting the length clears the pending mark on 3.
        set_length(LEN_W'(6));
        start_cycle(3);
        start_cycle(5);
        settle();

        // Length clamps: 0 behaves as 2, 127 as 64.
        set_length(LEN_W'(0));
        start_cycle(1);
        start_cycle(2);             // out of range after clamp
        settle();
        set_length(LEN_W'(127));
        start_cycle(40);
        settle();
        set_length(LEN_W'(64));
        start_cycle(63);
        settle();
    endtask

    // Phases of random length settings. Most of the traffic is a well-formed
    // parent load followed by starts; the rest is stray starts and loads
    // that corrupt the permutation or fall outside the length.
    task automatic test_random_phases();
        int unsigned stop_at;
        int unsigned n;
        int unsigned r;
        int unsigned e0;
        int unsigned target;
        stop_at = applied_items + RANDOM_ITEMS;
        while (applied_items < stop_at)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
                n = $urandom_range(2, 12);
            else if (r < 9)
                n = $urandom_range(13, 40);
            else
                n = GENE_SPAN;
            sender_steady = ($urandom_range(0, 3) == 0);
            sink_steady   = ($urandom_range(0, 3) == 0);
            set_length(LEN_W'(n));
            load_parents(n);
            e0     = emissions;
            target = $urandom_range(1, 2);
            for (int k = 0; k < 4 * n + 8; k++)
            begin
                if (emissions - e0 >= target)
                    break;
                r = $urandom_range(0, 99);
                if (r < 65)
                    start_cycle($urandom_range(0, n - 1));
                else if (r < 75)
                    start_cycle($urandom_range(0, GENE_SPAN - 1));
                else
                    load_gene($urandom_range(0, GENE_SPAN - 1), $urandom_range(0, 63),
                              $urandom_range(0, 63));
            end
            settle();
        end
        sender_steady = 1'b0;
        sink_steady   = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        cfg_write           = 1'b0;
        cfg_wdata           = '0;
        item_bus.valid      = 1'b0;
        item_bus.command    = CMD_LOAD;
        item_bus.position   = '0;
        item_bus.gene_a     = '0;
        item_bus.gene_b     = '0;
        result_bus.ready    = 1'b0;
        foreach (parent_a[i])
        begin
            parent_a[i]  = '0;
            parent_b[i]  = '0;
            slot_of_a[i] = '0;
        end
        clear_cycle();
        length_reg    = LEN_RESET;
        emissions     = 0;
        applied_items = 0;
        mismatches    = 0;
        burst_left    = 0;
        sender_steady = 1'b0;
        sink_steady   = 1'b0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_full_fill();
        test_directed();
        test_random_phases();
        settle();

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog, well beyond the slowest legal run.
    initial
    begin
        #50000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/pcx_pkg.sv
hdl/pcx_if.sv
hdl/pcx_gene_store.sv
hdl/permutation_cycle_crossover_top.sv
tb/tb.sv
